### rtl/lpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared constants and controller/datapath interface types for the LRU page
// tracker.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int PAGE_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 4;
  localparam int POS_W       = 3;
  localparam int OUT_PAGE_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(3);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_page;  // capture the incoming request
    logic update;     // search, evict and reorder the list
    logic emit;       // load the next list entry into the output register
  } lpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a new entry
    logic last_pos;   // current read position is the tail
  } lpt_status_t;

endpackage

### rtl/lpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_ctrl
// Controller: accepts one request, runs the list update, then walks the list
// out one entry per free output slot.
// ----------------------------------------------------------------------------
module lpt_ctrl
  import lpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  lpt_status_t status,
  output lpt_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    state_next    = state;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_page = 1'b1;
          state_next    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/lpt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_datapath
// Datapath: resident page list, occupancy, capacity register, parallel tag
// match, one read port shared by eviction and emission, output register.
// ----------------------------------------------------------------------------
module lpt_datapath
  import lpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CAP_W-1:0]       cfg_wdata,
  input  logic [PAGE_BITS-1:0]   in_page,
  input  lpt_cmd_t               cmd,
  output lpt_status_t            status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [POS_W-1:0]       out_position,
  output logic [OUT_PAGE_W-1:0]  out_entry_page,
  output logic                   out_last,
  output logic                   out_hit,
  output logic                   out_evicted_valid,
  output logic [OUT_PAGE_W-1:0]  out_evicted_page
);

  logic [PAGE_BITS-1:0] entries [MAX_ENTRIES];
  logic [PAGE_BITS-1:0] page;
  logic [OCC_W-1:0]     occ;
  logic [CAP_W-1:0]     capacity;
  logic [IDX_W-1:0]     pos;
  logic                 hit;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;

  logic [OCC_W-1:0]     cap_eff;
  logic                 found;
  logic [IDX_W-1:0]     where;
  logic                 full;
  logic [OCC_W-1:0]     occ_next;
  logic [OCC_W-1:0]     shift_top;
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] rd_data;

  // Clamp the capacity to 1..MAX_ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = OCC_W'(1);
    end else if (OCC_W'(capacity) > OCC_W'(MAX_ENTRIES)) begin
      cap_eff = OCC_W'(MAX_ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity);
    end
  end

  // Match the page against every resident entry, lowest position wins
  always_comb begin
    found = 1'b0;
    where = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if ((OCC_W'(i) < occ) && (entries[i] == page)) begin
        found = 1'b1;
        where = IDX_W'(i);
      end
    end
  end

  // Work out the new occupancy and how far the list shifts back
  always_comb begin
    full = (occ >= cap_eff);
    if (found) begin
      occ_next  = occ;
      shift_top = OCC_W'(where);
    end else begin
      occ_next  = full ? cap_eff : occ + OCC_W'(1);
      shift_top = occ_next - OCC_W'(1);
    end
  end

  // Shared read port: tail during the update, walk position while emitting
  assign rd_addr = cmd.emit ? pos : (occ[IDX_W-1:0] - IDX_W'(1));
  assign rd_data = entries[rd_addr];

  assign status.out_free = !out_valid || out_ready;
  assign status.last_pos = ((OCC_W'(pos) + OCC_W'(1)) == occ);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_page) begin
      page <= in_page;
    end
  end

  // Reorder the list: shift back up to the hit or insert point, new page at front
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      entries[0] <= page;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (OCC_W'(i) <= shift_top) begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  // Occupancy, read position and per-request flags
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      pos <= '0;
    end else begin
      if (cmd.update) begin
        occ <= occ_next;
        pos <= '0;
      end else if (cmd.emit) begin
        pos <= pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit      <= found;
      ev_valid <= !found && full;
      ev_page  <= (!found && full) ? rd_data : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_position      <= POS_W'(pos);
      out_entry_page    <= OUT_PAGE_W'(rd_data);
      out_last          <= status.last_pos;
      out_hit           <= hit;
      out_evicted_valid <= ev_valid;
      out_evicted_page  <= OUT_PAGE_W'(ev_page);
    end
  end

endmodule

### rtl/lru_page_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_tracker_top
// Least-recently-used tracker of resident pages. Each request references one
// page; the list is reordered and then sent out head to tail.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[15:0] page
//   m_axis    out        tdata: position, entry_page, evicted_page; tlast:
//                        last_entry; tuser: hit, evicted_valid
//   cfg       in         cfg_wdata[3:0] capacity, written when cfg_wen is high
//
// A request is accepted, then searched and reordered, then walked out entry
// by entry through the output register. A stalled output holds the walk; a
// new request is taken once the tail entry sits in the output register.
// Reset empties the list and sets capacity to 3.
// ----------------------------------------------------------------------------
module lru_page_tracker_top
  import lpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CAP_W-1:0]       cfg_wdata,      // capacity
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] page
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] position, [18:3] entry_page,
                                                 // [34:19] evicted_page, [39:35] zero
  output logic                   m_axis_tlast,   // last_entry
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] hit, [1] evicted_valid
);

  lpt_cmd_t              cmd;
  lpt_status_t           status;
  logic [POS_W-1:0]      position;
  logic [OUT_PAGE_W-1:0] entry_page;
  logic [OUT_PAGE_W-1:0] evicted_page;
  logic                  hit;
  logic                  evicted_valid;

  lpt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  lpt_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .in_page           (PAGE_BITS'(s_axis_tdata)),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_position      (position),
    .out_entry_page    (entry_page),
    .out_last          (m_axis_tlast),
    .out_hit           (hit),
    .out_evicted_valid (evicted_valid),
    .out_evicted_page  (evicted_page)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {5'b0, evicted_page, entry_page, position};
  assign m_axis_tuser = {evicted_valid, hit};

endmodule
